// File: rtl/rlee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlee_pkg
// Shared types, constants and register indexes of the run-length encoder.
// ----------------------------------------------------------------------------
package rlee_pkg;

    localparam int unsigned BYTE_W            = 8;
    localparam int unsigned CFG_IDX_W         = 2;
    localparam int unsigned CMD_DEPTH_DEFAULT = 4;

    localparam logic [BYTE_W-1:0] ESCAPE_RESET  = 8'h02;
    localparam logic [BYTE_W-1:0] MAX_RUN_RESET = 8'd250;
    localparam logic [BYTE_W-1:0] MIN_RUN_RESET = 8'd4;
    localparam logic [BYTE_W-1:0] MIN_RUN_CAP   = 8'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ESCAPE_CODE = 2'd0,
        CFG_MAX_RUN     = 2'd1,
        CFG_MIN_RUN     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] escape_code;
        logic [BYTE_W-1:0] max_run;
        logic [BYTE_W-1:0] min_run;
    } t_cfg;

    // One chunk of a run: sent as a block or as literal copies.
    typedef struct packed {
        logic              block;
        logic [BYTE_W-1:0] count;
        logic [BYTE_W-1:0] value;
    } t_chunk;

    // Work caused by one input item: the chunk cut off by the item and
    // the chunk flushed at the end of the stream.
    typedef struct packed {
        logic   a_valid;
        t_chunk a;
        logic   b_valid;
        t_chunk b;
        logic   stream_end;
    } t_cmd;

endpackage

// File: rtl/rlee_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlee_front
// Holds the current run and turns each accepted byte into a chunk command.
// ----------------------------------------------------------------------------
module rlee_front
    import rlee_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_stream_end,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd
);

    logic [BYTE_W-1:0] r_held_byte;
    logic [BYTE_W-1:0] n_held_byte;
    logic [BYTE_W-1:0] r_run_length;
    logic [BYTE_W-1:0] n_run_length;
    logic [BYTE_W-1:0] limit;
    logic [BYTE_W-1:0] grown_byte;
    logic [BYTE_W-1:0] grown_length;
    logic              extend;

    assign limit  = (i_cfg.min_run > MIN_RUN_CAP) ? MIN_RUN_CAP : i_cfg.min_run;
    assign extend = (r_run_length != '0) && (i_data_byte == r_held_byte)
                    && (r_run_length < i_cfg.max_run);

    assign grown_byte   = extend ? r_held_byte : i_data_byte;
    assign grown_length = extend ? (r_run_length + 8'd1) : 8'd1;

    always_comb begin
        o_cmd.a_valid    = !extend && (r_run_length != '0);
        o_cmd.a.value    = r_held_byte;
        o_cmd.a.count    = r_run_length;
        o_cmd.a.block    = (r_held_byte == i_cfg.escape_code) || (r_run_length >= limit);
        o_cmd.b_valid    = i_stream_end;
        o_cmd.b.value    = grown_byte;
        o_cmd.b.count    = grown_length;
        o_cmd.b.block    = (grown_byte == i_cfg.escape_code) || (grown_length >= limit);
        o_cmd.stream_end = i_stream_end;
        o_cmd_valid      = i_accept && (o_cmd.a_valid || o_cmd.b_valid);
    end

    always_comb begin
        n_held_byte  = r_held_byte;
        n_run_length = r_run_length;
        if (i_accept) begin
            n_held_byte  = grown_byte;
            n_run_length = i_stream_end ? '0 : grown_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte  <= '0;
            r_run_length <= '0;
        end else begin
            r_held_byte  <= n_held_byte;
            r_run_length <= n_run_length;
        end
    end

    a_end_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_stream_end) |=> (r_run_length == '0))
        else $error("Run still held after the end of a stream.");

endmodule

// File: rtl/rlee_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlee_cmd_fifo
// Short command queue between the front and the back of the encoder.
// ----------------------------------------------------------------------------
module rlee_cmd_fifo
    import rlee_pkg::*;
#(
    parameter int unsigned DEPTH = CMD_DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : (r_wr_ptr + 1'b1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : (r_rd_ptr + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("Command pushed into a full queue.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("Command popped from an empty queue.");

endmodule

// File: rtl/rlee_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlee_back
// Expands chunk commands into code bytes, one per cycle while the result
// register is empty or being popped, into that register.
// ----------------------------------------------------------------------------
module rlee_back
    import rlee_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BYTE_W-1:0] i_escape_code,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [BYTE_W-1:0] o_code_byte,
    output logic              o_item_done,
    output logic              o_stream_done
);

    logic              r_on_b;
    logic              n_on_b;
    logic [1:0]        r_idx;
    logic [1:0]        n_idx;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [BYTE_W-1:0] r_code_byte;
    logic              r_item_done;
    logic              r_stream_done;
    t_chunk            cur;
    logic              cur_is_b;
    logic [1:0]        len;
    logic              last_of_chunk;
    logic              last_of_cmd;
    logic              advance;
    logic [BYTE_W-1:0] next_byte;

    assign cur_is_b      = r_on_b || !i_cmd.a_valid;
    assign cur           = cur_is_b ? i_cmd.b : i_cmd.a;
    assign len           = cur.block ? 2'd3 : cur.count[1:0];
    assign last_of_chunk = (r_idx == (len - 2'd1));
    assign last_of_cmd   = last_of_chunk && (cur_is_b || !i_cmd.b_valid);
    assign advance       = i_cmd_valid && (!r_out_valid || i_pop);
    assign o_cmd_pop     = advance && last_of_cmd;

    always_comb begin
        next_byte = cur.value;
        if (cur.block) begin
            case (r_idx)
                2'd0:    next_byte = i_escape_code;
                2'd1:    next_byte = cur.count;
                default: next_byte = cur.value;
            endcase
        end
    end

    always_comb begin
        n_on_b      = r_on_b;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_pop;
        if (advance) begin
            n_out_valid = 1'b1;
            if (last_of_cmd) begin
                n_on_b = 1'b0;
                n_idx  = '0;
            end else if (last_of_chunk) begin
                n_on_b = 1'b1;
                n_idx  = '0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_b      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_on_b      <= n_on_b;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_code_byte   <= next_byte;
            r_item_done   <= last_of_cmd;
            r_stream_done <= last_of_cmd && i_cmd.stream_end;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_code_byte   = r_code_byte;
    assign o_item_done   = r_item_done;
    assign o_stream_done = r_stream_done;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd3)
        else $error("Byte index within a chunk out of range.");

    a_stream_done_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_stream_done) |-> r_item_done)
        else $error("End of stream marked on a byte that does not end its item.");

endmodule

// File: rtl/rle_escape_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_escape_encoder_unit
// Streaming run-length encoder with an escape byte.
// ----------------------------------------------------------------------------
// One byte is accepted every cycle while the command queue (CMD_DEPTH entries)
// has room; a byte that only extends the held run produces nothing. A byte
// that closes a chunk or ends the stream produces one to six code bytes, which
// leave through the result register at one byte per cycle while the reader
// pops, so the sustained rate is set by the output side: one code byte per
// cycle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module rle_escape_encoder_unit
    import rlee_pkg::*;
#(
    parameter int unsigned CMD_DEPTH = CMD_DEPTH_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_stream_end,
    output logic                 empty,
    input  logic                 pop,
    output logic [BYTE_W-1:0]    o_code_byte,
    output logic                 o_item_done,
    output logic                 o_stream_done
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic accept;
    logic cmd_valid;
    t_cmd cmd_in;
    t_cmd cmd_head;
    logic cmd_empty;
    logic cmd_pop;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ESCAPE_CODE: n_cfg.escape_code = i_cfg_data;
                CFG_MAX_RUN:     n_cfg.max_run     = i_cfg_data;
                CFG_MIN_RUN:     n_cfg.min_run     = i_cfg_data;
                default:         n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.escape_code <= ESCAPE_RESET;
            r_cfg.max_run     <= MAX_RUN_RESET;
            r_cfg.min_run     <= MIN_RUN_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign accept = push && !full;

    rlee_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd_in)
    );

    rlee_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_head)
    );

    rlee_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_escape_code (r_cfg.escape_code),
        .i_cmd_valid   (!cmd_empty),
        .i_cmd         (cmd_head),
        .o_cmd_pop     (cmd_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_code_byte   (o_code_byte),
        .o_item_done   (o_item_done),
        .o_stream_done (o_stream_done)
    );

endmodule
